FILE: hdl/bie_pkg.sv
// Shared constants, types and controller/datapath command structures for the binary image engine.
`timescale 1ns / 1ps

package bie_pkg;

    // Image geometry: the store holds MAX_SIZE rows of MAX_SIZE one-bit pixels.
    localparam int MAX_SIZE = 64;
    localparam int ADDR_W   = $clog2(MAX_SIZE);
    localparam int SIZE_W   = 7;
    localparam int OP_W     = 3;
    localparam int COORD_W  = 6;

    typedef logic [MAX_SIZE-1:0] row_t;

    // Operation codes carried by an input item.
    typedef enum logic [OP_W-1:0] {
        OP_WRITE      = 3'd0,
        OP_READ       = 3'd1,
        OP_INVERT     = 3'd2,
        OP_FLIP_V     = 3'd3,
        OP_FLIP_H     = 3'd4,
        OP_REMOVE_ISO = 3'd5
    } opcode_t;

    // Read address selection for the two memory read ports.
    typedef enum logic [2:0] {
        RD_PIX,
        RD_ROW,
        RD_PAIR,
        RD_ISO_UP,
        RD_ISO_DN
    } rd_sel_t;

    // Write selection: address and data source of the single write port.
    typedef enum logic [2:0] {
        WR_NONE,
        WR_PIX,
        WR_INV,
        WR_FLIP_V,
        WR_FH_LO,
        WR_FH_HI,
        WR_ISO
    } wr_sel_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_PX_RD,
        ST_PX_WR,
        ST_LOOP,
        ST_ROW_RD,
        ST_ROW_WR,
        ST_FH_RD,
        ST_FH_WR_LO,
        ST_FH_WR_HI,
        ST_ISO_RD0,
        ST_ISO_RD1,
        ST_ISO_WR,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_item;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    rd_en_a;
        logic    rd_en_b;
        logic    cap_up;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    load_result;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            more;
    } status_t;

endpackage

FILE: hdl/bie_req_if.sv
// Input item channel: opcode, coordinates and pixel value with valid/ready.
`timescale 1ns / 1ps

interface bie_req_if;
    logic                         valid;
    logic                         ready;
    logic [bie_pkg::OP_W-1:0]     opcode;
    logic [bie_pkg::COORD_W-1:0]  row;
    logic [bie_pkg::COORD_W-1:0]  col;
    logic                         pixel_in;

    modport source (output valid, output opcode, output row, output col, output pixel_in,
                    input ready);
    modport sink   (input valid, input opcode, input row, input col, input pixel_in,
                    output ready);
endinterface

FILE: hdl/bie_rsp_if.sv
// Result channel: pixel read and range flag with valid/ready.
`timescale 1ns / 1ps

interface bie_rsp_if;
    logic valid;
    logic ready;
    logic pixel_out;
    logic in_range;

    modport source (output valid, output pixel_out, output in_range, input ready);
    modport sink   (input valid, input pixel_out, input in_range, output ready);
endinterface

FILE: hdl/bie_cfg_if.sv
// Configuration write channel carrying the image side register.
`timescale 1ns / 1ps

interface bie_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bie_pkg::SIZE_W-1:0]  image_size;

    modport source (output valid, output image_size, input ready);
    modport sink   (input valid, input image_size, output ready);
endinterface

FILE: hdl/binary_image_ops_engine.sv
// Top level of the binary image engine: channels, controller and datapath.
`timescale 1ns / 1ps

// The engine keeps a square one-bit image of up to 64 by 64 pixels in a row
// memory (64 rows of 64 bits, one write and two read ports).
// The req channel carries one operation per transfer: write pixel, read pixel,
// invert, mirror about the vertical axis, mirror about the horizontal axis, or
// remove isolated pixels. Each transfer yields exactly one transfer on rsp.
// The cfg channel sets the side in use; it is always ready and is meant to be
// written only while the engine is idle.
// After a req transfer the engine dispatches the item; a pixel write or read
// then reads the row and, for a write, writes it back, and an unused opcode
// goes straight to the result. Whole-image operations sweep the rows: a loop
// check, one row read and one row write per row (for the horizontal-axis
// mirror one read of a row pair and two row writes per pair), plus a second
// read per row for the isolated-pixel window.
// One item is in work at a time; req is ready again right after the result is
// placed in the output register, so the next item is taken only after that.
// If the receiver stalls, a finished result waits in the controller until the
// output register is free, and no new item is taken meanwhile.
// Reset sets the side to 64 and returns the engine to idle; the image contents
// are undefined until written.
module binary_image_ops_engine (
    input logic      clk,
    input logic      rst_n,
    bie_req_if.sink  req,
    bie_rsp_if.source rsp,
    bie_cfg_if.sink  cfg
);

    bie_pkg::cmd_t    cmd;
    bie_pkg::status_t status;

    // Configuration writes are taken in any cycle.
    assign cfg.ready = 1'b1;

    // Sequencing of the operation steps.
    bie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Image memory and row transforms.
    bie_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg.valid),
        .cfg_data  (cfg.image_size),
        .opcode    (req.opcode),
        .row       (req.row),
        .col       (req.col),
        .pixel_in  (req.pixel_in),
        .pixel_out (rsp.pixel_out),
        .in_range  (rsp.in_range)
    );

endmodule

FILE: hdl/bie_ctrl.sv
// Controller state machine sequencing pixel and whole-image operations.
`timescale 1ns / 1ps

module bie_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  bie_pkg::status_t status,
    output bie_pkg::cmd_t    cmd
);

    bie_pkg::state_t state_reg;
    bie_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    // State and result-valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bie_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.rd_sel      = bie_pkg::RD_PIX;
        cmd.wr_sel      = bie_pkg::WR_NONE;

        unique case (state_reg)
            bie_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = bie_pkg::ST_DISPATCH;
                end
            end
            bie_pkg::ST_DISPATCH:
            begin
                unique case (status.op)
                    bie_pkg::OP_WRITE,
                    bie_pkg::OP_READ:
                    begin
                        state_next = bie_pkg::ST_PX_RD;
                    end
                    bie_pkg::OP_INVERT,
                    bie_pkg::OP_FLIP_V,
                    bie_pkg::OP_FLIP_H,
                    bie_pkg::OP_REMOVE_ISO:
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = bie_pkg::ST_LOOP;
                    end
                    default:
                    begin
                        state_next = bie_pkg::ST_DONE;
                    end
                endcase
            end
            bie_pkg::ST_PX_RD:
            begin
                cmd.rd_en_a = 1'b1;
                cmd.rd_sel  = bie_pkg::RD_PIX;
                state_next  = bie_pkg::ST_PX_WR;
            end
            bie_pkg::ST_PX_WR:
            begin
                if (status.op == bie_pkg::OP_WRITE)
                begin
                    cmd.wr_sel = bie_pkg::WR_PIX;
                end
                state_next = bie_pkg::ST_DONE;
            end
            bie_pkg::ST_LOOP:
            begin
                if (!status.more)
                begin
                    state_next = bie_pkg::ST_DONE;
                end
                else if (status.op == bie_pkg::OP_FLIP_H)
                begin
                    state_next = bie_pkg::ST_FH_RD;
                end
                else if (status.op == bie_pkg::OP_REMOVE_ISO)
                begin
                    state_next = bie_pkg::ST_ISO_RD0;
                end
                else
                begin
                    state_next = bie_pkg::ST_ROW_RD;
                end
            end
            bie_pkg::ST_ROW_RD:
            begin
                cmd.rd_en_a = 1'b1;
                cmd.rd_sel  = bie_pkg::RD_ROW;
                state_next  = bie_pkg::ST_ROW_WR;
            end
            bie_pkg::ST_ROW_WR:
            begin
                cmd.wr_sel  = (status.op == bie_pkg::OP_INVERT) ? bie_pkg::WR_INV
                                                                : bie_pkg::WR_FLIP_V;
                cmd.cnt_inc = 1'b1;
                state_next  = bie_pkg::ST_LOOP;
            end
            bie_pkg::ST_FH_RD:
            begin
                cmd.rd_en_a = 1'b1;
                cmd.rd_en_b = 1'b1;
                cmd.rd_sel  = bie_pkg::RD_PAIR;
                state_next  = bie_pkg::ST_FH_WR_LO;
            end
            bie_pkg::ST_FH_WR_LO:
            begin
                cmd.wr_sel = bie_pkg::WR_FH_LO;
                state_next = bie_pkg::ST_FH_WR_HI;
            end
            bie_pkg::ST_FH_WR_HI:
            begin
                cmd.wr_sel  = bie_pkg::WR_FH_HI;
                cmd.cnt_inc = 1'b1;
                state_next  = bie_pkg::ST_LOOP;
            end
            bie_pkg::ST_ISO_RD0:
            begin
                cmd.rd_en_a = 1'b1;
                cmd.rd_en_b = 1'b1;
                cmd.rd_sel  = bie_pkg::RD_ISO_UP;
                state_next  = bie_pkg::ST_ISO_RD1;
            end
            bie_pkg::ST_ISO_RD1:
            begin
                cmd.rd_en_a = 1'b1;
                cmd.cap_up  = 1'b1;
                cmd.rd_sel  = bie_pkg::RD_ISO_DN;
                state_next  = bie_pkg::ST_ISO_WR;
            end
            bie_pkg::ST_ISO_WR:
            begin
                cmd.wr_sel  = bie_pkg::WR_ISO;
                cmd.cnt_inc = 1'b1;
                state_next  = bie_pkg::ST_LOOP;
            end
            bie_pkg::ST_DONE:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = bie_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bie_pkg::ST_IDLE;
            end
        endcase
    end

    // Result valid: set on load, cleared when the receiver takes the transfer.
    always_comb
    begin
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_ready  = (state_reg == bie_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/bie_datapath.sv
// Datapath: image row memory, item and size registers, row counter and row transforms.
`timescale 1ns / 1ps

module bie_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bie_pkg::cmd_t                cmd,
    output bie_pkg::status_t             status,
    input  logic                         cfg_we,
    input  logic [bie_pkg::SIZE_W-1:0]   cfg_data,
    input  logic [bie_pkg::OP_W-1:0]     opcode,
    input  logic [bie_pkg::COORD_W-1:0]  row,
    input  logic [bie_pkg::COORD_W-1:0]  col,
    input  logic                         pixel_in,
    output logic                         pixel_out,
    output logic                         in_range
);

    logic [bie_pkg::SIZE_W-1:0]   image_size_reg;
    logic [bie_pkg::SIZE_W-1:0]   cnt_reg;
    logic [bie_pkg::OP_W-1:0]     op_reg;
    logic [bie_pkg::COORD_W-1:0]  row_reg;
    logic [bie_pkg::COORD_W-1:0]  col_reg;
    logic                         pix_in_reg;
    logic                         pixel_out_reg;
    logic                         in_range_reg;

    bie_pkg::row_t                mem [bie_pkg::MAX_SIZE];
    bie_pkg::row_t                rd_a_reg;
    bie_pkg::row_t                rd_b_reg;
    bie_pkg::row_t                up_reg;

    logic [bie_pkg::SIZE_W-1:0]   side;
    logic [bie_pkg::SIZE_W-1:0]   limit;
    logic [bie_pkg::SIZE_W-1:0]   mirror_full;
    logic [bie_pkg::SIZE_W-1:0]   shamt;
    logic [bie_pkg::ADDR_W-1:0]   cnt_addr;
    logic [bie_pkg::ADDR_W-1:0]   mirror_addr;
    logic [bie_pkg::ADDR_W-1:0]   up_addr;
    logic [bie_pkg::ADDR_W-1:0]   dn_addr;
    logic [bie_pkg::ADDR_W-1:0]   rd_addr_a;
    logic [bie_pkg::ADDR_W-1:0]   rd_addr_b;
    logic [bie_pkg::ADDR_W-1:0]   wr_addr;
    logic                         wr_en;
    logic                         inr;
    bie_pkg::row_t                wr_data;
    bie_pkg::row_t                mask;
    bie_pkg::row_t                pix_row;
    bie_pkg::row_t                rev_row;
    bie_pkg::row_t                flip_row;
    bie_pkg::row_t                up_v;
    bie_pkg::row_t                mid_v;
    bie_pkg::row_t                dn_v;
    bie_pkg::row_t                nb;
    bie_pkg::row_t                iso;

    // Side register, written from the configuration channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg <= bie_pkg::SIZE_W'(bie_pkg::MAX_SIZE);
        end
        else if (cfg_we)
        begin
            image_size_reg <= cfg_data;
        end
    end

    // Row counter for whole-image sweeps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_clr)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.cnt_inc)
        begin
            cnt_reg <= cnt_reg + bie_pkg::SIZE_W'(1);
        end
    end

    // Item fields captured on an input transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg     <= opcode;
            row_reg    <= row;
            col_reg    <= col;
            pix_in_reg <= pixel_in;
        end
    end

    // Side in use saturates at the store size; columns below it form the mask.
    always_comb
    begin
        side = (image_size_reg > bie_pkg::SIZE_W'(bie_pkg::MAX_SIZE))
             ? bie_pkg::SIZE_W'(bie_pkg::MAX_SIZE) : image_size_reg;
        for (int k = 0; k < bie_pkg::MAX_SIZE; k++)
        begin
            mask[k] = (bie_pkg::SIZE_W'(k) < side);
        end
    end

    assign inr = ({1'b0, row_reg} < side) && ({1'b0, col_reg} < side);

    // Loop bound: row pairs for the horizontal-axis flip, rows otherwise.
    assign limit       = (op_reg == bie_pkg::OP_FLIP_H) ? (side >> 1) : side;
    assign status.op   = op_reg;
    assign status.more = (cnt_reg < limit);

    // Row addresses derived from the counter.
    assign mirror_full = side - bie_pkg::SIZE_W'(1) - cnt_reg;
    assign cnt_addr    = cnt_reg[bie_pkg::ADDR_W-1:0];
    assign mirror_addr = mirror_full[bie_pkg::ADDR_W-1:0];
    assign up_addr     = cnt_addr - bie_pkg::ADDR_W'(1);
    assign dn_addr     = cnt_addr + bie_pkg::ADDR_W'(1);

    // Read address selection.
    always_comb
    begin
        rd_addr_b = cnt_addr;
        unique case (cmd.rd_sel)
            bie_pkg::RD_PIX:    rd_addr_a = row_reg;
            bie_pkg::RD_ROW:    rd_addr_a = cnt_addr;
            bie_pkg::RD_PAIR:
            begin
                rd_addr_a = cnt_addr;
                rd_addr_b = mirror_addr;
            end
            bie_pkg::RD_ISO_UP: rd_addr_a = up_addr;
            bie_pkg::RD_ISO_DN: rd_addr_a = dn_addr;
            default:            rd_addr_a = cnt_addr;
        endcase
    end

    // Row memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en_a)
        begin
            rd_a_reg <= mem[rd_addr_a];
        end
        if (cmd.rd_en_b)
        begin
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    // Row above the current one during isolated-pixel removal.
    always_ff @(posedge clk)
    begin
        if (cmd.cap_up)
        begin
            up_reg <= rd_a_reg;
        end
    end

    // Single pixel update inside the fetched row.
    always_comb
    begin
        pix_row          = rd_a_reg;
        pix_row[col_reg] = pix_in_reg;
    end

    // Column mirror: reverse the row, then align the used columns to bit zero.
    always_comb
    begin
        for (int k = 0; k < bie_pkg::MAX_SIZE; k++)
        begin
            rev_row[k] = rd_a_reg[bie_pkg::MAX_SIZE-1-k];
        end
        shamt    = bie_pkg::SIZE_W'(bie_pkg::MAX_SIZE) - side;
        flip_row = ((rev_row >> shamt) & mask) | (rd_a_reg & ~mask);
    end

    // Isolated pixels: set in the middle row with no other set pixel in the 3x3 window.
    always_comb
    begin
        up_v  = (cnt_reg == '0) ? '0 : (up_reg & mask);
        mid_v = rd_b_reg & mask;
        dn_v  = ((cnt_reg + bie_pkg::SIZE_W'(1)) >= side) ? '0 : (rd_a_reg & mask);
        nb    = up_v | (up_v << 1) | (up_v >> 1)
              | dn_v | (dn_v << 1) | (dn_v >> 1)
              | (mid_v << 1) | (mid_v >> 1);
        iso   = mid_v & ~nb;
    end

    // Write port selection.
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = cnt_addr;
        wr_data = rd_a_reg;
        unique case (cmd.wr_sel)
            bie_pkg::WR_NONE:
            begin
                wr_en = 1'b0;
            end
            bie_pkg::WR_PIX:
            begin
                wr_en   = inr;
                wr_addr = row_reg;
                wr_data = pix_row;
            end
            bie_pkg::WR_INV:
            begin
                wr_data = rd_a_reg ^ mask;
            end
            bie_pkg::WR_FLIP_V:
            begin
                wr_data = flip_row;
            end
            bie_pkg::WR_FH_LO:
            begin
                wr_data = (rd_b_reg & mask) | (rd_a_reg & ~mask);
            end
            bie_pkg::WR_FH_HI:
            begin
                wr_addr = mirror_addr;
                wr_data = (rd_a_reg & mask) | (rd_b_reg & ~mask);
            end
            bie_pkg::WR_ISO:
            begin
                wr_data = rd_b_reg & ~iso;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Result register feeding the output channel.
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            pixel_out_reg <= (op_reg == bie_pkg::OP_READ) && inr && rd_a_reg[col_reg];
            in_range_reg  <= ((op_reg == bie_pkg::OP_READ) || (op_reg == bie_pkg::OP_WRITE))
                             && inr;
        end
    end

    assign pixel_out = pixel_out_reg;
    assign in_range  = in_range_reg;

endmodule

FILE: tb/sv/tb_binary_image_ops_engine.sv
// Self-checking testbench for the binary image engine: directed and random operations.
`timescale 1ns / 1ps

module tb_binary_image_ops_engine;

    // Opcodes outside the package enum; the engine treats them as no operation.
    localparam logic [bie_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [bie_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

    // Side of the corner region written pixel by pixel before any whole-image operation.
    localparam int FILL_SIDE    = 6;
    // Items sent by the random phases.
    localparam int RANDOM_ITEMS = 70;

    // One result of the engine as it appears on the rsp channel.
    typedef struct packed {
        logic pixel_out;
        logic in_range;
    } px_answer_t;

    logic clk;
    logic rst_n;

    bie_req_if req_ch ();
    bie_rsp_if rsp_ch ();
    bie_cfg_if cfg_ch ();

    binary_image_ops_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the image and of the side register.
    bie_pkg::row_t              img_rows  [bie_pkg::MAX_SIZE];
    bie_pkg::row_t              img_snap  [bie_pkg::MAX_SIZE];
    bit                         img_known [bie_pkg::MAX_SIZE][bie_pkg::MAX_SIZE];
    logic [bie_pkg::SIZE_W-1:0] img_side;

    // Answers owed by the engine, oldest first.
    px_answer_t pixel_answers [$];
    px_answer_t got_want;

    int errors;
    int items_sent;
    int rsp_stall;
    bit gaps_on;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Hard limit on the run time.
    initial
    begin
        #30_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Side in use after saturation at the store size.
    function automatic int side_in_use();
        return (img_side > bie_pkg::MAX_SIZE) ? bie_pkg::MAX_SIZE : int'(img_side);
    endfunction

    // Pixel of the snapshot; positions outside the image read as clear.
    function automatic bit snap_px(int n, int r, int c);
        if (r < 0 || c < 0 || r >= n || c >= n)
            return 1'b0;
        return img_snap[r][c];
    endfunction

    // True when every pixel of an n by n image has been written.
    function automatic bit all_known(int n);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                if (!img_known[i][j])
                    return 1'b0;
        return 1'b1;
    endfunction

    // Applies one accepted item to the shadow image and queues the answer it owes.
    task automatic image_op_apply(input logic [bie_pkg::OP_W-1:0] op,
                                  input logic [bie_pkg::COORD_W-1:0] r,
                                  input logic [bie_pkg::COORD_W-1:0] c, input logic v);
        int         n;
        int         i;
        int         j;
        int         dr;
        int         dc;
        bit         inr;
        bit         lone;
        logic       t;
        px_answer_t ans;
        n   = side_in_use();
        inr = (int'(r) < n) && (int'(c) < n);
        ans = '0;
        case (op)
            bie_pkg::OP_WRITE:
            begin
                if (inr)
                begin
                    img_rows[r][c]  = v;
                    img_known[r][c] = 1'b1;
                end
                ans.in_range = inr;
            end
            bie_pkg::OP_READ:
            begin
                if (inr)
                    ans.pixel_out = img_rows[r][c];
                ans.in_range = inr;
            end
            bie_pkg::OP_INVERT:
            begin
                for (i = 0; i < n; i++)
                    for (j = 0; j < n; j++)
                        img_rows[i][j] = ~img_rows[i][j];
            end
            bie_pkg::OP_FLIP_V:
            begin
                for (i = 0; i < n; i++)
                    for (j = 0; j < n / 2; j++)
                    begin
                        t                    = img_rows[i][j];
                        img_rows[i][j]       = img_rows[i][n-1-j];
                        img_rows[i][n-1-j]   = t;
                    end
            end
            bie_pkg::OP_FLIP_H:
            begin
                for (i = 0; i < n; i++)
                    for (j = 0; j < n / 2; j++)
                    begin
                        t                    = img_rows[j][i];
                        img_rows[j][i]       = img_rows[n-1-j][i];
                        img_rows[n-1-j][i]   = t;
                    end
            end
            bie_pkg::OP_REMOVE_ISO:
            begin
                // Each pixel is judged on the image as it was before the sweep.
                img_snap = img_rows;
                for (i = 0; i < n; i++)
                    for (j = 0; j < n; j++)
                        if (img_snap[i][j])
                        begin
                            lone = 1'b1;
                            for (dr = -1; dr <= 1; dr++)
                                for (dc = -1; dc <= 1; dc++)
                                    if ((dr != 0 || dc != 0) && snap_px(n, i + dr, j + dc))
                                        lone = 1'b0;
                            if (lone)
                                img_rows[i][j] = 1'b0;
                        end
            end
            default:
            begin
            end
        endcase
        pixel_answers.push_back(ans);
    endtask

    // Sends one item on req and records its answer once the transfer takes place.
    task automatic send_item(input logic [bie_pkg::OP_W-1:0] op,
                             input logic [bie_pkg::COORD_W-1:0] r,
                             input logic [bie_pkg::COORD_W-1:0] c, input logic v);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.opcode   <= op;
        req_ch.row      <= r;
        req_ch.col      <= c;
        req_ch.pixel_in <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
        image_op_apply(op, r, c, v);
    endtask

    // Drops valid and waits until every owed answer has arrived.
    task automatic settle_engine();
        req_ch.valid <= 1'b0;
        while (pixel_answers.size() != 0)
            @(posedge clk);
    endtask

    // Writes the side register once the engine is idle.
    task automatic cfg_write(input logic [bie_pkg::SIZE_W-1:0] value);
        settle_engine();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.image_size <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        img_side = value;
    endtask

    // Random coordinate, inside the side in use when asked and possible.
    function automatic logic [bie_pkg::COORD_W-1:0] pick_coord(int n, bit want_in);
        if (want_in && n > 0)
            return bie_pkg::COORD_W'($urandom_range(0, n - 1));
        if (n < bie_pkg::MAX_SIZE)
            return bie_pkg::COORD_W'($urandom_range(n, bie_pkg::MAX_SIZE - 1));
        return bie_pkg::COORD_W'($urandom_range(0, bie_pkg::MAX_SIZE - 1));
    endfunction

    // Builds a 3x3 window around a random center, removes isolated pixels and reads the center.
    task automatic iso_window(input int n);
        int cr;
        int cc;
        int dr;
        int dc;
        logic v;
        cr = $urandom_range(0, n - 1);
        cc = $urandom_range(0, n - 1);
        for (dr = -1; dr <= 1; dr++)
            for (dc = -1; dc <= 1; dc++)
                if (cr + dr >= 0 && cr + dr < n && cc + dc >= 0 && cc + dc < n)
                begin
                    // Now and then a neighbor is set so the center survives.
                    if (dr == 0 && dc == 0)
                        v = 1'b1;
                    else
                        v = ($urandom_range(0, 11) == 0);
                    send_item(bie_pkg::OP_WRITE, bie_pkg::COORD_W'(cr + dr),
                              bie_pkg::COORD_W'(cc + dc), v);
                end
        send_item(bie_pkg::OP_REMOVE_ISO, '0, '0, 1'b0);
        send_item(bie_pkg::OP_READ, bie_pkg::COORD_W'(cr), bie_pkg::COORD_W'(cc), 1'b0);
    endtask

    // Writes every pixel of the corner region used by whole-image operations.
    task automatic test_fill_store();
        int r;
        int c;
        cfg_write(bie_pkg::SIZE_W'(bie_pkg::MAX_SIZE));
        gaps_on = 1'b0;
        for (r = 0; r < FILL_SIDE; r++)
            for (c = 0; c < FILL_SIDE; c++)
                send_item(bie_pkg::OP_WRITE, bie_pkg::COORD_W'(r), bie_pkg::COORD_W'(c),
                          ($urandom_range(0, 3) == 0));
        gaps_on = 1'b1;
    endtask

    // Reads and writes at the corners of the full image.
    task automatic test_pixel_access();
        send_item(bie_pkg::OP_READ, '0, '0, 1'b0);
        send_item(bie_pkg::OP_WRITE, '1, '1, 1'b1);
        send_item(bie_pkg::OP_READ, '1, '1, 1'b0);
        send_item(bie_pkg::OP_WRITE, '0, '1, 1'b0);
        send_item(bie_pkg::OP_READ, '0, '1, 1'b0);
    endtask

    // Coordinates beyond a small side: writes are dropped and reads give zero.
    task automatic test_out_of_range();
        cfg_write(bie_pkg::SIZE_W'(5));
        send_item(bie_pkg::OP_WRITE, 6'd5, 6'd2, 1'b1);
        send_item(bie_pkg::OP_WRITE, 6'd2, 6'd63, 1'b1);
        send_item(bie_pkg::OP_READ, 6'd5, 6'd0, 1'b0);
        send_item(bie_pkg::OP_READ, 6'd0, 6'd5, 1'b0);
        send_item(bie_pkg::OP_READ, 6'd4, 6'd4, 1'b0);
    endtask

    // Whole-image operations on an odd side, where the middle row and column stay in place.
    task automatic test_odd_side_ops();
        send_item(bie_pkg::OP_FLIP_V, '0, '0, 1'b0);
        send_item(bie_pkg::OP_FLIP_H, '0, '0, 1'b0);
        send_item(bie_pkg::OP_INVERT, '0, '0, 1'b0);
        send_item(bie_pkg::OP_REMOVE_ISO, '0, '0, 1'b0);
        send_item(bie_pkg::OP_READ, 6'd2, 6'd2, 1'b0);
    endtask

    // Side zero: nothing is in range and whole-image operations change nothing.
    task automatic test_side_zero();
        cfg_write('0);
        send_item(bie_pkg::OP_WRITE, '0, '0, 1'b1);
        send_item(bie_pkg::OP_READ, '0, '0, 1'b0);
        send_item(bie_pkg::OP_INVERT, '0, '0, 1'b0);
    endtask

    // A side above the store size saturates to the full image.
    task automatic test_side_saturation();
        cfg_write('1);
        send_item(bie_pkg::OP_READ, '1, '1, 1'b0);
        send_item(bie_pkg::OP_WRITE, '1, '0, 1'b1);
        send_item(bie_pkg::OP_READ, '1, '0, 1'b0);
    endtask

    // A one-pixel image: a set pixel there is always isolated.
    task automatic test_single_pixel_side();
        cfg_write(bie_pkg::SIZE_W'(1));
        send_item(bie_pkg::OP_WRITE, '0, '0, 1'b1);
        send_item(bie_pkg::OP_REMOVE_ISO, '0, '0, 1'b0);
        send_item(bie_pkg::OP_READ, '0, '0, 1'b0);
    endtask

    // Spare opcodes answer with all zero.
    task automatic test_unused_opcodes();
        send_item(OP_SPARE_6, '1, '1, 1'b1);
        send_item(OP_SPARE_7, '0, '0, 1'b1);
    endtask

    // Phases of random items, each under a fresh side and idling mode.
    task automatic test_random_phases();
        int                          n;
        int                          k;
        int                          count;
        int                          start;
        bit                          want_in;
        bit                          whole_ok;
        logic [bie_pkg::SIZE_W-1:0]  sz;
        logic [bie_pkg::COORD_W-1:0] r;
        logic [bie_pkg::COORD_W-1:0] c;
        logic [bie_pkg::COORD_W-1:0] t;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            // Mostly small sides; the extremes now and then.
            k = $urandom_range(0, 19);
            if (k == 0)
                sz = '0;
            else if (k == 1)
                sz = bie_pkg::SIZE_W'($urandom_range(bie_pkg::MAX_SIZE + 1, 127));
            else if (k == 2)
                sz = bie_pkg::SIZE_W'(bie_pkg::MAX_SIZE);
            else if (k == 3)
                sz = bie_pkg::SIZE_W'(1);
            else if (k == 4)
                sz = bie_pkg::SIZE_W'(bie_pkg::MAX_SIZE - 1);
            else
                sz = bie_pkg::SIZE_W'($urandom_range(2, FILL_SIDE));
            cfg_write(sz);
            gaps_on  = ($urandom_range(0, 3) != 0);
            n        = side_in_use();
            whole_ok = all_known(n);
            if (n > 0 && whole_ok && $urandom_range(0, 2) == 0)
                iso_window(n);
            count = $urandom_range(8, 20);
            repeat (count)
            begin
                want_in = ($urandom_range(0, 6) != 0);
                r = pick_coord(n, want_in || ($urandom_range(0, 1) == 1));
                c = pick_coord(n, want_in);
                if ($urandom_range(0, 1) == 1)
                begin
                    t = r;
                    r = c;
                    c = t;
                end
                k = $urandom_range(0, 99);
                // Anything that would see a pixel never written becomes a write.
                if (k >= 60 && k < 96 && !whole_ok)
                    k = 0;
                if (k >= 35 && k < 60 && int'(r) < n && int'(c) < n && !img_known[r][c])
                    k = 0;
                if (k < 35)
                    send_item(bie_pkg::OP_WRITE, r, c, ($urandom_range(0, 2) == 0));
                else if (k < 60)
                    send_item(bie_pkg::OP_READ, r, c, 1'($urandom_range(0, 1)));
                else if (k < 68)
                    send_item(bie_pkg::OP_FLIP_V, r, c, 1'($urandom_range(0, 1)));
                else if (k < 76)
                    send_item(bie_pkg::OP_FLIP_H, r, c, 1'($urandom_range(0, 1)));
                else if (k < 86)
                    send_item(bie_pkg::OP_REMOVE_ISO, r, c, 1'($urandom_range(0, 1)));
                else if (k < 96)
                    send_item(bie_pkg::OP_INVERT, r, c, 1'($urandom_range(0, 1)));
                else if (k < 98)
                    send_item(OP_SPARE_6, r, c, 1'($urandom_range(0, 1)));
                else
                    send_item(OP_SPARE_7, r, c, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Result checking and receiver stalls: each transfer on rsp is compared with the oldest answer.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b1;
            rsp_stall = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pixel_answers.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: expected none, actual %0b %0b",
                             $time, rsp_ch.pixel_out, rsp_ch.in_range);
                end
                else
                begin
                    got_want = pixel_answers.pop_front();
                    if (got_want.pixel_out !== rsp_ch.pixel_out)
                    begin
                        errors++;
                        $display("%0t: pixel_out mismatch: expected %0b actual %0b",
                                 $time, got_want.pixel_out, rsp_ch.pixel_out);
                    end
                    if (got_want.in_range !== rsp_ch.in_range)
                    begin
                        errors++;
                        $display("%0t: in_range mismatch: expected %0b actual %0b",
                                 $time, got_want.in_range, rsp_ch.in_range);
                    end
                end
                rsp_stall = gaps_on ? $urandom_range(0, 5) : 0;
                if (rsp_stall != 0)
                    rsp_ch.ready <= 1'b0;
            end
            else if (rsp_stall != 0)
            begin
                rsp_stall--;
                if (rsp_stall == 0)
                    rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Reset, the test sequence and the final verdict.
    initial
    begin
        errors     = 0;
        items_sent = 0;
        gaps_on    = 1'b1;
        img_side   = bie_pkg::SIZE_W'(bie_pkg::MAX_SIZE);
        foreach (img_rows[i])
            img_rows[i] = '0;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= '0;
        req_ch.row        <= '0;
        req_ch.col        <= '0;
        req_ch.pixel_in   <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.image_size <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_store();
        test_pixel_access();
        test_out_of_range();
        test_odd_side_ops();
        test_side_zero();
        test_side_saturation();
        test_single_pixel_side();
        test_unused_opcodes();
        test_random_phases();

        // Let the last transfers land and give the engine time to show any stray result.
        settle_engine();
        repeat (300) @(posedge clk);
        if (errors == 0 && pixel_answers.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
